/* rtl/core/bpfp_pkg.sv */
`default_nettype none

package bpfp_pkg;

  localparam int W_IN    = 24;
  localparam int W_OUT   = 25;
  localparam int W_Q     = 32;
  localparam int W_N     = 62;
  localparam int W_MAG   = 31;
  localparam int W_WIDE  = 68;
  localparam int SQ_STEPS = 31;
  localparam int Q_BITS  = 32;
  localparam int W_REM   = 93;
  localparam int SIDE_W_DEF = 1;

  localparam logic signed [W_WIDE-1:0] OUT_MAX = 68'sd16777215;

  typedef logic signed [W_IN-1:0]   in_t;
  typedef logic signed [W_Q-1:0]    q30_t;
  typedef logic signed [W_OUT-1:0]  res_comp_t;
  typedef logic signed [W_WIDE-1:0] wide_t;

  // per-item context inside the unit-vector pipeline
  typedef struct packed {
    logic [2:0][W_MAG-1:0] mag;
    logic [2:0]            sgn;
    logic                  zero;
    logic [4:0]            e;
  } ctx_t;

  // words carried alongside the beam unit vector
  typedef struct packed {
    in_t  px;
    in_t  py;
    in_t  pz;
    in_t  vx;
    in_t  vy;
    in_t  vz;
    logic deg;
    logic bzero;
  } side1_t;

  // words carried alongside the transverse unit vector
  typedef struct packed {
    q30_t kx;
    q30_t ky;
    q30_t kz;
    in_t  vx;
    in_t  vy;
    in_t  vz;
    logic deg;
    logic ikill;
  } side2_t;

  typedef struct packed {
    res_comp_t oi;
    res_comp_t oj;
    res_comp_t ok;
    logic      deg;
  } res_t;

  // pairs of leading zeros to bring n up to at least 2^60
  function automatic logic [4:0] lead_pairs(input logic [W_N-1:0] n);
    logic [4:0] e;
    e = 5'd30;
    for (int j = 0; j < 31; j++) begin
      if (n[2*j +: 2] != 2'b00) e = 5'(30 - j);
    end
    return e;
  endfunction

  // divide by 2^t, round half away from zero
  function automatic wide_t rnd68(input wide_t x, input int t);
    logic [W_WIDE-1:0] m;
    m = x[W_WIDE-1] ? W_WIDE'(-x) : W_WIDE'(x);
    m = (m + (68'd1 << (t - 1))) >> t;
    return x[W_WIDE-1] ? -$signed(m) : $signed(m);
  endfunction

  function automatic res_comp_t sat25(input wide_t r);
    res_comp_t y;
    if (r > OUT_MAX) y = res_comp_t'(OUT_MAX);
    else if (r < -OUT_MAX) y = res_comp_t'(-OUT_MAX);
    else y = r[W_OUT-1:0];
    return y;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/bpfp_unit.sv */
`default_nettype none

module bpfp_unit import bpfp_pkg::*; #(
  parameter int SIDE_W = SIDE_W_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              adv,
  input  logic              in_valid,
  input  q30_t              c [3],
  input  logic [W_N-1:0]    n,
  input  logic [SIDE_W-1:0] side,
  output logic              out_valid,
  output q30_t              u [3],
  output logic [SIDE_W-1:0] side_out
);

  localparam int ST_M   = 1;
  localparam int ST_SQ0 = 2;
  localparam int ST_R   = ST_SQ0 + SQ_STEPS;
  localparam int ST_D0  = ST_R + 1;
  localparam int ST_U   = ST_D0 + Q_BITS;
  localparam int DEPTH  = ST_U + 1;

  logic              vld [DEPTH];
  ctx_t              ctx [DEPTH];
  logic [SIDE_W-1:0] sd  [DEPTH];
  ctx_t              ctx_in;
  logic [W_N-1:0]    n0_q;
  logic [W_N-1:0]    m_q;
  logic [W_N-1:0]    sq_rem [SQ_STEPS];
  logic [W_N-1:0]    sq_res [SQ_STEPS];
  logic [W_MAG-1:0]  s_d [Q_BITS+1];
  logic [W_REM-1:0]  div_r [3][Q_BITS+1];
  logic [Q_BITS-1:0] div_q [3][Q_BITS+1];
  q30_t              u_q [3];

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      ctx_in.mag[a] = c[a][W_Q-1] ? W_MAG'(-c[a]) : c[a][W_MAG-1:0];
      ctx_in.sgn[a] = c[a][W_Q-1];
    end
    ctx_in.zero = (n == '0);
    ctx_in.e    = lead_pairs(n);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int g = 0; g < DEPTH; g++) vld[g] <= 1'b0;
    end else if (adv) begin
      vld[0] <= in_valid;
      for (int g = 1; g < DEPTH; g++) vld[g] <= vld[g-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ctx[0] <= ctx_in;
      sd[0]  <= side;
      n0_q   <= n;
      for (int g = 1; g < DEPTH; g++) begin
        ctx[g] <= ctx[g-1];
        sd[g]  <= sd[g-1];
      end
      m_q <= n0_q << {ctx[0].e, 1'b0};
    end
  end

  // digit-by-digit square root, one step a stage
  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sq
    localparam logic [W_N-1:0] BIT = 62'd1 << (60 - 2*k);
    logic [W_N-1:0] rin;
    logic [W_N-1:0] sin;
    logic [W_N-1:0] t;
    if (k == 0) begin : g_first
      assign rin = m_q;
      assign sin = '0;
    end else begin : g_next
      assign rin = sq_rem[k-1];
      assign sin = sq_res[k-1];
    end
    assign t = sin + BIT;
    always_ff @(posedge clk) begin
      if (adv) begin
        if (rin >= t) begin
          sq_rem[k] <= rin - t;
          sq_res[k] <= (sin >> 1) + BIT;
        end else begin
          sq_rem[k] <= rin;
          sq_res[k] <= sin >> 1;
        end
      end
    end
  end

  // rounded dividend, then restoring division one quotient bit a stage
  always_ff @(posedge clk) begin
    if (adv) begin
      s_d[0] <= sq_res[SQ_STEPS-1][W_MAG-1:0];
      for (int a = 0; a < 3; a++) begin
        div_r[a][0] <= (W_REM'(ctx[ST_R-1].mag[a]) << (30 + int'(ctx[ST_R-1].e)))
                       + W_REM'(sq_res[SQ_STEPS-1][W_MAG-1:1]);
        div_q[a][0] <= '0;
      end
      for (int d = 0; d < Q_BITS; d++) s_d[d+1] <= s_d[d];
    end
  end

  for (genvar a = 0; a < 3; a++) begin : g_lane
    for (genvar d = 0; d < Q_BITS; d++) begin : g_div
      localparam int SH = Q_BITS - 1 - d;
      logic [W_REM-1:0] dv;
      assign dv = W_REM'(s_d[d]) << SH;
      always_ff @(posedge clk) begin
        if (adv) begin
          if (div_r[a][d] >= dv) begin
            div_r[a][d+1] <= div_r[a][d] - dv;
            div_q[a][d+1] <= div_q[a][d] | (Q_BITS'(1) << SH);
          end else begin
            div_r[a][d+1] <= div_r[a][d];
            div_q[a][d+1] <= div_q[a][d];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int a = 0; a < 3; a++) begin
        if (ctx[ST_U-1].zero) u_q[a] <= '0;
        else if (ctx[ST_U-1].sgn[a]) u_q[a] <= -$signed(div_q[a][Q_BITS]);
        else u_q[a] <= $signed(div_q[a][Q_BITS]);
      end
    end
  end

  assign out_valid = vld[DEPTH-1];
  assign u         = u_q;
  assign side_out  = sd[DEPTH-1];

`ifndef SYNTHESIS
  a_norm: assert property (@(posedge clk) disable iff (rst)
    vld[ST_M] && !ctx[ST_M].zero |-> m_q[W_N-1:W_N-2] != 2'b00)
    else $error("normalised norm below 2^60");
  a_root: assert property (@(posedge clk) disable iff (rst)
    vld[ST_R] && !ctx[ST_R].zero |-> s_d[0][W_MAG-1])
    else $error("square root lost its top bit");
  a_zero: assert property (@(posedge clk) disable iff (rst)
    vld[ST_U] && ctx[ST_U].zero |-> u_q[0] == 0 && u_q[1] == 0 && u_q[2] == 0)
    else $error("zero vector gave a nonzero unit");
`endif

endmodule

`default_nettype wire

/* rtl/core/beam_photon_frame_projection_core.sv */
// channel | handshake            | word
// input   | in_valid / in_stall  | beam_x..z, photon_x..z, vec_x..z
// output  | out_valid / out_stall| out_i, out_j, out_k, degenerate
//
// one word accepted per cycle while in_stall is low; each word passes the two unit-vector
// pipelines (31-step square root plus 32-step divider each)
// synchronous active-high rst clears valid bits and the output buffer
// the whole pipeline advances together; a two-word output buffer takes the
// stall, so input keeps flowing while one result waits
`default_nettype none

module beam_photon_frame_projection_core import bpfp_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic signed [W_IN-1:0] beam_x,
  input  logic signed [W_IN-1:0] beam_y,
  input  logic signed [W_IN-1:0] beam_z,
  input  logic signed [W_IN-1:0] photon_x,
  input  logic signed [W_IN-1:0] photon_y,
  input  logic signed [W_IN-1:0] photon_z,
  input  logic signed [W_IN-1:0] vec_x,
  input  logic signed [W_IN-1:0] vec_y,
  input  logic signed [W_IN-1:0] vec_z,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic signed [W_OUT-1:0] out_i,
  output logic signed [W_OUT-1:0] out_j,
  output logic signed [W_OUT-1:0] out_k,
  output logic                   degenerate
);

  logic adv;

  // stage 1: cross-product terms and beam squares
  logic              v1;
  side1_t            s1_side;
  in_t               s1_b [3];
  logic signed [47:0] s1_xp [6];
  logic [47:0]       s1_bsq [3];

  // stage 2: parallel test and beam norm
  logic              v2;
  side1_t            s2_side;
  q30_t              s2_c [3];
  logic [W_N-1:0]    s2_n;

  // beam unit vector
  logic              u1_valid;
  q30_t              u1_k [3];
  logic [$bits(side1_t)-1:0] u1_side_raw;
  side1_t            u1_side;

  // middle stages: transverse part of the photon
  logic              vm1, vm2, vm3, vm4, vm5, vm6, vm7;
  side1_t            m1_side, m2_side, m3_side, m4_side;
  q30_t              m1_k [3];
  q30_t              m2_k [3];
  q30_t              m3_k [3];
  q30_t              m4_k [3];
  logic signed [55:0] m1_pk [3];
  logic signed [35:0] m2_d;
  wide_t             m3_dk [3];
  logic signed [39:0] m4_x [3];
  side2_t            m5_side, m6_side, m7_side;
  logic [29:0]       m5_mag [3];
  logic [29:0]       m6_mag [3];
  logic [2:0]        m5_sgn, m6_sgn;
  logic [59:0]       m6_sq [3];
  q30_t              m7_c [3];
  logic [W_N-1:0]    m7_n;

  logic [39:0]       x_mag [3];
  logic [39:0]       x_or;
  logic [3:0]        x_sh;
  logic              x_zero;

  // transverse unit vector
  logic              u2_valid;
  q30_t              u2_i [3];
  logic [$bits(side2_t)-1:0] u2_side_raw;
  side2_t            u2_side;

  // tail: cross product for j, then the three projections
  logic              vq1, vq2, vq3;
  side2_t            q1_side, q2_side;
  q30_t              q1_i [3];
  q30_t              q2_i [3];
  q30_t              q2_j [3];
  logic signed [63:0] q1_ki [6];
  logic signed [55:0] q3_vi [3];
  logic signed [55:0] q3_vj [3];
  logic signed [55:0] q3_vk [3];
  logic              q3_deg, q3_ikill;

  // output buffer
  res_t              fifo [2];
  res_t              res_new;
  logic              wp, rp;
  logic [1:0]        cnt, cnt_next;
  logic              push, pop;

  assign adv      = (cnt != 2'd2);
  assign in_stall = !adv;

  // ---------------- stage 1 ----------------
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_side.px <= photon_x;
      s1_side.py <= photon_y;
      s1_side.pz <= photon_z;
      s1_side.vx <= vec_x;
      s1_side.vy <= vec_y;
      s1_side.vz <= vec_z;
      s1_side.deg   <= 1'b0;
      s1_side.bzero <= 1'b0;
      s1_b[0] <= beam_x;
      s1_b[1] <= beam_y;
      s1_b[2] <= beam_z;
      s1_xp[0] <= 48'(beam_y) * 48'(photon_z);
      s1_xp[1] <= 48'(beam_z) * 48'(photon_y);
      s1_xp[2] <= 48'(beam_z) * 48'(photon_x);
      s1_xp[3] <= 48'(beam_x) * 48'(photon_z);
      s1_xp[4] <= 48'(beam_x) * 48'(photon_y);
      s1_xp[5] <= 48'(beam_y) * 48'(photon_x);
      s1_bsq[0] <= 48'(48'(beam_x) * 48'(beam_x));
      s1_bsq[1] <= 48'(48'(beam_y) * 48'(beam_y));
      s1_bsq[2] <= 48'(48'(beam_z) * 48'(beam_z));
    end
  end

  // ---------------- stage 2 ----------------
  always_ff @(posedge clk) begin
    if (adv) begin
      s2_side.px    <= s1_side.px;
      s2_side.py    <= s1_side.py;
      s2_side.pz    <= s1_side.pz;
      s2_side.vx    <= s1_side.vx;
      s2_side.vy    <= s1_side.vy;
      s2_side.vz    <= s1_side.vz;
      s2_side.deg   <= (s1_xp[0] == s1_xp[1]) && (s1_xp[2] == s1_xp[3]) &&
                       (s1_xp[4] == s1_xp[5]);
      s2_side.bzero <= (s1_b[0] == 0) && (s1_b[1] == 0) && (s1_b[2] == 0);
      for (int a = 0; a < 3; a++) s2_c[a] <= W_Q'(s1_b[a]);
      s2_n <= W_N'(s1_bsq[0]) + W_N'(s1_bsq[1]) + W_N'(s1_bsq[2]);
    end
  end

  bpfp_unit #(
    .SIDE_W ($bits(side1_t))
  ) u_beam_unit (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (v2),
    .c         (s2_c),
    .n         (s2_n),
    .side      (s2_side),
    .out_valid (u1_valid),
    .u         (u1_k),
    .side_out  (u1_side_raw)
  );

  assign u1_side = side1_t'(u1_side_raw);

  // ---------------- middle stages ----------------
  always_ff @(posedge clk) begin
    if (adv) begin
      // p.k products
      m1_side <= u1_side;
      m1_k    <= u1_k;
      m1_pk[0] <= 56'(u1_side.px) * 56'(u1_k[0]);
      m1_pk[1] <= 56'(u1_side.py) * 56'(u1_k[1]);
      m1_pk[2] <= 56'(u1_side.pz) * 56'(u1_k[2]);
      // p.k in Q.8
      m2_side <= m1_side;
      m2_k    <= m1_k;
      m2_d    <= 36'(rnd68(W_WIDE'(m1_pk[0]) + W_WIDE'(m1_pk[1]) + W_WIDE'(m1_pk[2]), 22));
      // (p.k) k
      m3_side <= m2_side;
      m3_k    <= m2_k;
      for (int a = 0; a < 3; a++) m3_dk[a] <= W_WIDE'(m2_d) * W_WIDE'(m2_k[a]);
      // transverse part, photon itself when the beam is zero
      m4_side <= m3_side;
      m4_k    <= m3_k;
      if (m3_side.bzero) begin
        m4_x[0] <= 40'(m3_side.px);
        m4_x[1] <= 40'(m3_side.py);
        m4_x[2] <= 40'(m3_side.pz);
      end else begin
        m4_x[0] <= (40'(m3_side.px) <<< 8) - 40'(rnd68(m3_dk[0], 30));
        m4_x[1] <= (40'(m3_side.py) <<< 8) - 40'(rnd68(m3_dk[1], 30));
        m4_x[2] <= (40'(m3_side.pz) <<< 8) - 40'(rnd68(m3_dk[2], 30));
      end
    end
  end

  // halve until every component sits below 2^30
  always_comb begin
    x_or = '0;
    x_sh = '0;
    for (int a = 0; a < 3; a++) begin
      x_mag[a] = m4_x[a][39] ? 40'(-m4_x[a]) : 40'(m4_x[a]);
      x_or     = x_or | x_mag[a];
    end
    for (int hb = 30; hb < 40; hb++) begin
      if (x_or[hb]) x_sh = 4'(hb - 29);
    end
    x_zero = (x_or == '0);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m5_side.kx    <= m4_k[0];
      m5_side.ky    <= m4_k[1];
      m5_side.kz    <= m4_k[2];
      m5_side.vx    <= m4_side.vx;
      m5_side.vy    <= m4_side.vy;
      m5_side.vz    <= m4_side.vz;
      m5_side.deg   <= m4_side.deg | x_zero;
      m5_side.ikill <= !m4_side.bzero & (m4_side.deg | x_zero);
      for (int a = 0; a < 3; a++) begin
        m5_mag[a] <= 30'(x_mag[a] >> x_sh);
        m5_sgn[a] <= m4_x[a][39];
      end
      // squares of the transverse part
      m6_side <= m5_side;
      m6_mag  <= m5_mag;
      m6_sgn  <= m5_sgn;
      for (int a = 0; a < 3; a++) m6_sq[a] <= 60'(m5_mag[a]) * 60'(m5_mag[a]);
      // norm and signed components for the second unit
      m7_side <= m6_side;
      m7_n    <= W_N'(m6_sq[0]) + W_N'(m6_sq[1]) + W_N'(m6_sq[2]);
      for (int a = 0; a < 3; a++) begin
        m7_c[a] <= m6_sgn[a] ? -$signed(W_Q'(m6_mag[a])) : $signed(W_Q'(m6_mag[a]));
      end
    end
  end

  bpfp_unit #(
    .SIDE_W ($bits(side2_t))
  ) u_trans_unit (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (vm7),
    .c         (m7_c),
    .n         (m7_n),
    .side      (m7_side),
    .out_valid (u2_valid),
    .u         (u2_i),
    .side_out  (u2_side_raw)
  );

  assign u2_side = side2_t'(u2_side_raw);

  // ---------------- tail stages ----------------
  always_ff @(posedge clk) begin
    if (adv) begin
      // parallel or degenerate transverse part with a nonzero beam: i is zero
      q1_side <= u2_side;
      for (int a = 0; a < 3; a++) q1_i[a] <= u2_side.ikill ? '0 : u2_i[a];
      q1_ki[0] <= 64'(u2_side.ky) * 64'(u2_side.ikill ? q30_t'(0) : u2_i[2]);
      q1_ki[1] <= 64'(u2_side.kz) * 64'(u2_side.ikill ? q30_t'(0) : u2_i[1]);
      q1_ki[2] <= 64'(u2_side.kz) * 64'(u2_side.ikill ? q30_t'(0) : u2_i[0]);
      q1_ki[3] <= 64'(u2_side.kx) * 64'(u2_side.ikill ? q30_t'(0) : u2_i[2]);
      q1_ki[4] <= 64'(u2_side.kx) * 64'(u2_side.ikill ? q30_t'(0) : u2_i[1]);
      q1_ki[5] <= 64'(u2_side.ky) * 64'(u2_side.ikill ? q30_t'(0) : u2_i[0]);
      // j = k x i
      q2_side <= q1_side;
      q2_i    <= q1_i;
      for (int a = 0; a < 3; a++) begin
        q2_j[a] <= W_Q'(rnd68(W_WIDE'(q1_ki[2*a]) - W_WIDE'(q1_ki[2*a+1]), 30));
      end
      // projection products
      q3_deg   <= q2_side.deg;
      q3_ikill <= q2_side.ikill;
      q3_vi[0] <= 56'(q2_side.vx) * 56'(q2_i[0]);
      q3_vi[1] <= 56'(q2_side.vy) * 56'(q2_i[1]);
      q3_vi[2] <= 56'(q2_side.vz) * 56'(q2_i[2]);
      q3_vj[0] <= 56'(q2_side.vx) * 56'(q2_j[0]);
      q3_vj[1] <= 56'(q2_side.vy) * 56'(q2_j[1]);
      q3_vj[2] <= 56'(q2_side.vz) * 56'(q2_j[2]);
      q3_vk[0] <= 56'(q2_side.vx) * 56'(q2_side.kx);
      q3_vk[1] <= 56'(q2_side.vy) * 56'(q2_side.ky);
      q3_vk[2] <= 56'(q2_side.vz) * 56'(q2_side.kz);
    end
  end

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      v1  <= 1'b0;
      v2  <= 1'b0;
      vm1 <= 1'b0;
      vm2 <= 1'b0;
      vm3 <= 1'b0;
      vm4 <= 1'b0;
      vm5 <= 1'b0;
      vm6 <= 1'b0;
      vm7 <= 1'b0;
      vq1 <= 1'b0;
      vq2 <= 1'b0;
      vq3 <= 1'b0;
    end else if (adv) begin
      v1  <= in_valid;
      v2  <= v1;
      vm1 <= u1_valid;
      vm2 <= vm1;
      vm3 <= vm2;
      vm4 <= vm3;
      vm5 <= vm4;
      vm6 <= vm5;
      vm7 <= vm6;
      vq1 <= u2_valid;
      vq2 <= vq1;
      vq3 <= vq2;
    end
  end

  // sums, rounding and saturation straight into the output buffer
  always_comb begin
    res_new.oi  = sat25(rnd68(W_WIDE'(q3_vi[0]) + W_WIDE'(q3_vi[1]) + W_WIDE'(q3_vi[2]), 30));
    res_new.oj  = sat25(rnd68(W_WIDE'(q3_vj[0]) + W_WIDE'(q3_vj[1]) + W_WIDE'(q3_vj[2]), 30));
    res_new.ok  = sat25(rnd68(W_WIDE'(q3_vk[0]) + W_WIDE'(q3_vk[1]) + W_WIDE'(q3_vk[2]), 30));
    res_new.deg = q3_deg;
  end

  assign push = adv && vq3;
  assign pop  = out_valid && !out_stall;

  always_comb begin
    cnt_next = cnt;
    if (push && !pop) cnt_next = cnt + 2'd1;
    else if (pop && !push) cnt_next = cnt - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      wp  <= 1'b0;
      rp  <= 1'b0;
    end else begin
      cnt <= cnt_next;
      if (push) wp <= !wp;
      if (pop) rp <= !rp;
    end
  end

  always_ff @(posedge clk) begin
    if (push) fifo[wp] <= res_new;
  end

  assign out_valid  = (cnt != 2'd0);
  assign out_i      = fifo[rp].oi;
  assign out_j      = fifo[rp].oj;
  assign out_k      = fifo[rp].ok;
  assign degenerate = fifo[rp].deg;

`ifndef SYNTHESIS
  a_cnt: assert property (@(posedge clk) disable iff (rst) cnt != 2'd3)
    else $error("output buffer overfilled");
  a_push: assert property (@(posedge clk) disable iff (rst) push |=> cnt != 2'd0)
    else $error("pushed word not held in output buffer");
  a_kill: assert property (@(posedge clk) disable iff (rst)
    vq3 && q3_ikill |-> q3_vi[0] == 0 && q3_vi[1] == 0 && q3_vi[2] == 0)
    else $error("parallel case left a nonzero i projection");
`endif

endmodule

`default_nettype wire

/* bench/frame_projection_checker.sv */
`default_nettype none

module frame_projection_checker import bpfp_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  input  logic                    in_stall,
  input  logic signed [W_IN-1:0]  beam_x,
  input  logic signed [W_IN-1:0]  beam_y,
  input  logic signed [W_IN-1:0]  beam_z,
  input  logic signed [W_IN-1:0]  photon_x,
  input  logic signed [W_IN-1:0]  photon_y,
  input  logic signed [W_IN-1:0]  photon_z,
  input  logic signed [W_IN-1:0]  vec_x,
  input  logic signed [W_IN-1:0]  vec_y,
  input  logic signed [W_IN-1:0]  vec_z,
  input  logic                    out_valid,
  input  logic                    out_stall,
  input  logic signed [W_OUT-1:0] out_i,
  input  logic signed [W_OUT-1:0] out_j,
  input  logic signed [W_OUT-1:0] out_k,
  input  logic                    degenerate,
  output int                      fails,
  output int                      pending,
  output int                      deg_seen,
  output int                      words_out
);

  res_t proj_queue[$];

  function automatic longint unsigned mag_of(input longint x);
    return x < 0 ? longint'(0) - x : x;
  endfunction

  // shift right by t, rounding half away from zero
  function automatic longint round_shift(input longint x, input int t);
    longint unsigned m;
    m = (mag_of(x) + (64'd1 << (t - 1))) >> t;
    return x < 0 ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint unsigned root62(input longint unsigned m);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 60;
    for (int s = 0; s < 31; s++) begin
      if (m >= r + b) begin
        m = m - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // q2.30 unit vector, zero for a zero vector
  function automatic void unit_q30(input longint c[3], output longint u[3]);
    longint unsigned n, m, s;
    logic [127:0] num, q;
    int e;
    n = 0;
    for (int a = 0; a < 3; a++) n += mag_of(c[a]) * mag_of(c[a]);
    for (int a = 0; a < 3; a++) u[a] = 0;
    if (n != 0) begin
      m = n;
      e = 0;
      while (m < (64'd1 << 60)) begin
        m = m << 2;
        e++;
      end
      s = root62(m);
      for (int a = 0; a < 3; a++) begin
        num = 128'(mag_of(c[a])) << (30 + e);
        q = (num + 128'(s >> 1)) / 128'(s);
        u[a] = c[a] < 0 ? -longint'(q[63:0]) : longint'(q[63:0]);
      end
    end
  endfunction

  function automatic res_comp_t dot_sat(input longint v[3], input longint u[3]);
    longint r;
    r = round_shift(v[0] * u[0] + v[1] * u[1] + v[2] * u[2], 30);
    if (r > 16777215) r = 16777215;
    if (r < -16777215) r = -16777215;
    return res_comp_t'(r);
  endfunction

  function automatic res_t frame_project(input longint b[3], input longint p[3],
                                         input longint v[3]);
    longint k[3], ih[3], jh[3], x[3];
    longint d;
    logic par, big;
    res_t r;
    for (int a = 0; a < 3; a++) begin
      ih[a] = 0;
      jh[a] = 0;
    end
    par = (b[1] * p[2] - b[2] * p[1]) == 0 && (b[2] * p[0] - b[0] * p[2]) == 0 &&
          (b[0] * p[1] - b[1] * p[0]) == 0;
    unit_q30(b, k);
    if (b[0] == 0 && b[1] == 0 && b[2] == 0) begin
      unit_q30(p, ih);
    end else if (!par) begin
      d = round_shift(p[0] * k[0] + p[1] * k[1] + p[2] * k[2], 22);
      for (int a = 0; a < 3; a++) x[a] = p[a] * 256 - round_shift(d * k[a], 30);
      do begin
        big = 0;
        for (int a = 0; a < 3; a++) if (mag_of(x[a]) >= (64'd1 << 30)) big = 1;
        if (big) for (int a = 0; a < 3; a++) x[a] = x[a] / 2;
      end while (big);
      if (x[0] == 0 && x[1] == 0 && x[2] == 0) begin
        par = 1;
      end else begin
        unit_q30(x, ih);
        jh[0] = round_shift(k[1] * ih[2] - k[2] * ih[1], 30);
        jh[1] = round_shift(k[2] * ih[0] - k[0] * ih[2], 30);
        jh[2] = round_shift(k[0] * ih[1] - k[1] * ih[0], 30);
      end
    end
    r.oi = dot_sat(v, ih);
    r.oj = dot_sat(v, jh);
    r.ok = dot_sat(v, k);
    r.deg = par;
    return r;
  endfunction

  always @(posedge clk) begin
    longint b[3], p[3], v[3];
    res_t want;
    if (rst) begin
      fails <= 0;
      deg_seen <= 0;
      words_out <= 0;
      pending <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        words_out <= words_out + 1;
        if (degenerate) deg_seen <= deg_seen + 1;
        if (proj_queue.size() == 0) begin
          if (fails < 10) $display("unexpected result word at %0t", $realtime);
          fails <= fails + 1;
        end else begin
          want = proj_queue.pop_front();
          if (want.oi !== out_i || want.oj !== out_j || want.ok !== out_k ||
              want.deg !== degenerate) begin
            if (fails < 10)
              $display("mismatch: exp i=%0d j=%0d k=%0d deg=%0b got i=%0d j=%0d k=%0d deg=%0b",
                       want.oi, want.oj, want.ok, want.deg, out_i, out_j, out_k,
                       degenerate);
            fails <= fails + 1;
          end
        end
      end
      if (in_valid && !in_stall) begin
        b = '{longint'(beam_x), longint'(beam_y), longint'(beam_z)};
        p = '{longint'(photon_x), longint'(photon_y), longint'(photon_z)};
        v = '{longint'(vec_x), longint'(vec_y), longint'(vec_z)};
        proj_queue.push_back(frame_project(b, p, v));
      end
      pending <= proj_queue.size();
    end
  end

endmodule

`default_nettype wire

/* bench/tb_beam_photon_frame_projection_core.sv */
`default_nettype none

module tb_beam_photon_frame_projection_core import bpfp_pkg::*; ();

  localparam int PIPE_LAT = 147;
  localparam int N_RANDOM = 1330;
  localparam logic signed [W_IN-1:0] MAX_IN = 24'sh7fffff;
  localparam logic signed [W_IN-1:0] MIN_IN = -24'sh800000;

  logic clk, rst;
  logic in_valid, in_stall, out_valid, out_stall, degenerate;
  logic signed [W_IN-1:0] beam_x, beam_y, beam_z;
  logic signed [W_IN-1:0] photon_x, photon_y, photon_z;
  logic signed [W_IN-1:0] vec_x, vec_y, vec_z;
  logic signed [W_OUT-1:0] out_i, out_j, out_k;
  int fails, pending, deg_seen, words_out;
  int words_in;

  beam_photon_frame_projection_core dut (.*);

  frame_projection_checker chk (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #20000000;
    $display("timeout, %0d words still outstanding", pending);
    $display("Regression FAIL");
    $finish;
  end

  // random gap length: mostly short, now and then long
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // receiver back-pressure, with quiet stretches where it never stalls
  initial begin
    int n;
    out_stall = 1'b0;
    @(negedge clk);
    forever begin
      if ($urandom_range(0, 3) == 0) begin
        out_stall = 1'b0;
        repeat ($urandom_range(20, 120)) @(negedge clk);
      end else begin
        n = gap_len();
        out_stall = (n != 0);
        repeat (n == 0 ? $urandom_range(1, 6) : n) @(negedge clk);
      end
    end
  end

  // present one word at a falling edge and hold it until taken
  task automatic send_word(input logic signed [W_IN-1:0] bx, by, bz, px, py, pz,
                           vx, vy, vz);
    logic taken;
    @(negedge clk);
    beam_x = bx; beam_y = by; beam_z = bz;
    photon_x = px; photon_y = py; photon_z = pz;
    vec_x = vx; vec_y = vy; vec_z = vz;
    in_valid = 1'b1;
    taken = 1'b0;
    while (!taken) begin
      taken = !in_stall;
      @(posedge clk);
      if (!taken) @(negedge clk);
    end
    words_in++;
  endtask

  task automatic idle_gap(input int n);
    repeat (n) begin
      @(negedge clk);
      in_valid = 1'b0;
    end
  endtask

  function automatic logic signed [W_IN-1:0] rand_comp();
    case ($urandom_range(0, 5))
      0: return W_IN'($urandom_range(0, 15) - 8);
      1: return W_IN'($urandom_range(0, 2047) - 1024);
      2: return ($urandom_range(0, 1) != 0) ? MAX_IN : MIN_IN;
      3: return '0;
      default: return W_IN'($urandom);
    endcase
  endfunction

  initial begin
    logic signed [W_IN-1:0] bx, by, bz, px, py, pz;
    int c;
    rst = 1'b1;
    in_valid = 1'b0;
    words_in = 0;
    {beam_x, beam_y, beam_z, photon_x, photon_y, photon_z, vec_x, vec_y, vec_z} = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed words: zeros, extremes, degenerate frames, saturation
    send_word(0, 0, 0, 0, 0, 0, 5, 6, 7);
    send_word(0, 0, 0, 3, 4, 0, 100, 200, 300);
    send_word(0, 0, 0, MIN_IN, MIN_IN, MIN_IN, MAX_IN, MAX_IN, MAX_IN);
    send_word(5, 0, 0, 0, 0, 0, 9, 9, 9);
    send_word(0, 0, 7, 0, 0, 21, 1, 2, 3);
    send_word(1, 2, 3, -2, -4, -6, 1000, -1000, 1000);
    send_word(MIN_IN, MIN_IN, MIN_IN, MAX_IN, MAX_IN, MAX_IN, 11, 22, 33);
    send_word(MIN_IN, 0, 0, MIN_IN, 0, 0, MIN_IN, MIN_IN, MIN_IN);
    send_word(1, 1, 1, 5, -3, 2, MAX_IN, MAX_IN, MAX_IN);
    send_word(1, 1, 1, -1, 2, 0, MIN_IN, MIN_IN, MIN_IN);
    send_word(0, 0, 1, 1, 0, 0, MAX_IN, MIN_IN, MAX_IN);
    send_word(MAX_IN, MAX_IN, MAX_IN, MIN_IN, MAX_IN, MIN_IN, MIN_IN, MAX_IN, 0);
    // nearly parallel photon: transverse part tiny or rounding away
    send_word(MAX_IN, 1, 0, MAX_IN, 0, 0, 123, 456, 789);
    send_word(MAX_IN, MAX_IN, MAX_IN - 1, 1, 1, 1, 7, -7, 7);
    send_word(MIN_IN, MAX_IN, 1, MIN_IN, MAX_IN, 0, 1, 1, 1);
    send_word(3, -4, 12, 1, 0, 0, -1, -1, -1);
    send_word(MAX_IN, 0, 0, 0, MAX_IN, 0, 1, 0, 0);
    send_word(-1, -1, -1, 1, 1, -1, 0, 0, 0);

    for (int n = 0; n < N_RANDOM; n++) begin
      bx = rand_comp(); by = rand_comp(); bz = rand_comp();
      case ($urandom_range(0, 9))
        0: begin  // photon along the beam, scaled
          c = $urandom_range(0, 6) - 3;
          px = W_IN'(bx * c); py = W_IN'(by * c); pz = W_IN'(bz * c);
        end
        1: begin  // zero beam
          bx = '0; by = '0; bz = '0;
          px = rand_comp(); py = rand_comp(); pz = rand_comp();
        end
        2: begin  // almost parallel
          px = bx; py = by; pz = W_IN'(bz + $urandom_range(0, 2) - 1);
        end
        default: begin
          px = rand_comp(); py = rand_comp(); pz = rand_comp();
        end
      endcase
      send_word(bx, by, bz, px, py, pz, rand_comp(), rand_comp(), rand_comp());
      // let the pipeline drain completely once mid-run
      if (n == N_RANDOM / 2) begin
        idle_gap(1);
        while (pending != 0) @(negedge clk);
      end else begin
        idle_gap(gap_len());
      end
    end
    @(negedge clk);
    in_valid = 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (PIPE_LAT + 50) @(negedge clk);
    $display("%0d words sent, %0d results checked, %0d of them degenerate frames",
             words_in, words_out, deg_seen);
    if (fails == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches, %0d results missing", fails, pending);
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
